// ----- rtl/tmt_pkg.sv -----
// Shared widths and reset constants for the tick-to-millisecond timebase.
package tmt_pkg;

    localparam int SAMPLE_WIDTH        = 32;
    localparam int TOTAL_WIDTH         = 32;
    localparam int TPM_WIDTH           = 27;
    localparam int COUNT_WIDTH_DEFAULT = 32;

    localparam logic [TPM_WIDTH-1:0] TPM_RESET = TPM_WIDTH'(10000);

endpackage

// ----- rtl/tmt_sample_if.sv -----
// Valid/ready channel that carries one tick-counter sample per transfer.
interface tmt_sample_if;

    logic                              valid;
    logic                              ready;
    logic [tmt_pkg::SAMPLE_WIDTH-1:0]  tick_sample;

    modport source (output valid, output tick_sample, input ready);
    modport sink   (input valid, input tick_sample, output ready);

endinterface

// ----- rtl/tmt_total_if.sv -----
// Valid/ready channel that carries one millisecond total per transfer.
interface tmt_total_if;

    logic                             valid;
    logic                             ready;
    logic [tmt_pkg::TOTAL_WIDTH-1:0]  ms_total;

    modport source (output valid, output ms_total, input ready);
    modport sink   (input valid, input ms_total, output ready);

endinterface

// ----- rtl/tick_to_millisecond_timebase.sv -----
// Top level: converts tick-counter samples into a running millisecond total.
// Sequence: an accepted sample runs the restoring divider in ST_DIV, then
// ST_FIN registers the result; ST_DIV is skipped when no ticks elapsed or
// the divisor is zero. A sample is taken only in ST_IDLE, after the previous
// one is through; one quotient bit per cycle, and a held result stalls ST_FIN.
// Reset (rst_n, asynchronous, active low) clears the tick mark and the total
// and loads ticks_per_ms with 10000.
module tick_to_millisecond_timebase #(
    parameter int COUNT_WIDTH = tmt_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tmt_pkg::TPM_WIDTH-1:0] cfg_wdata,
    tmt_sample_if.sink                    sample,
    tmt_total_if.source                   result
);

    localparam int TW    = tmt_pkg::TPM_WIDTH;
    localparam int CNT_W = $clog2(COUNT_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } state_t;

    // Control state.
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;

    // Arithmetic and architectural state.
    logic [TW-1:0]            tpm_reg, tpm_next;
    logic [COUNT_WIDTH-1:0]   mark_reg, mark_next;
    logic [COUNT_WIDTH-1:0]   total_reg, total_next;
    logic [COUNT_WIDTH-1:0]   sample_reg, sample_next;
    // The dividend register shifts out dividend bits at the top and takes in
    // quotient bits at the bottom, so it holds the quotient when done.
    logic [COUNT_WIDTH-1:0]   quot_reg, quot_next;
    logic [TW-1:0]            rem_reg, rem_next;
    logic                     skip_reg, skip_next;
    logic [tmt_pkg::TOTAL_WIDTH-1:0] out_data_reg, out_data_next;

    logic [COUNT_WIDTH-1:0]   sample_ext;
    logic [COUNT_WIDTH-1:0]   elapsed;
    logic [TW:0]              rem_shift;
    logic                     rem_fits;
    logic                     in_xfer;
    logic                     out_free;

    assign sample.ready  = (state_reg == ST_IDLE);
    assign in_xfer       = sample.valid && sample.ready;
    assign result.valid  = out_valid_reg;
    assign result.ms_total = out_data_reg;
    assign out_free      = !out_valid_reg || result.ready;

    // A narrower counter drops the upper sample bits; a wider one zero-extends.
    assign sample_ext = COUNT_WIDTH'(sample.tick_sample);
    assign elapsed    = sample_ext - mark_reg;

    // One step of the shared restoring divider.
    assign rem_shift = {rem_reg, quot_reg[COUNT_WIDTH-1]};
    assign rem_fits  = rem_shift >= {1'b0, tpm_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        tpm_next       = tpm_reg;
        mark_next      = mark_reg;
        total_next     = total_reg;
        sample_next    = sample_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        skip_next      = skip_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            tpm_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    sample_next = sample_ext;
                    quot_next   = elapsed - COUNT_WIDTH'(1);
                    rem_next    = '0;
                    count_next  = CNT_W'(COUNT_WIDTH - 1);
                    // No credit when no ticks elapsed or the divisor is zero.
                    skip_next   = (elapsed == '0) || (tpm_reg == '0);
                    state_next  = ((elapsed == '0) || (tpm_reg == '0)) ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_fits ? TW'(rem_shift - {1'b0, tpm_reg}) : TW'(rem_shift);
                quot_next = {quot_reg[COUNT_WIDTH-2:0], rem_fits};
                if (count_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    // k * ticks_per_ms equals (d - 1) - remainder, so the new mark
                    // is sample - 1 - remainder and no multiplier is needed.
                    if (!skip_reg)
                    begin
                        mark_next     = sample_reg - COUNT_WIDTH'(1) - COUNT_WIDTH'(rem_reg);
                        total_next    = total_reg + quot_reg;
                        out_data_next = tmt_pkg::TOTAL_WIDTH'(total_reg + quot_reg);
                    end
                    else
                    begin
                        out_data_next = tmt_pkg::TOTAL_WIDTH'(total_reg);
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            tpm_reg       <= tmt_pkg::TPM_RESET;
            mark_reg      <= '0;
            total_reg     <= '0;
            skip_reg      <= 1'b0;
            sample_reg    <= '0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            tpm_reg       <= tpm_next;
            mark_reg      <= mark_next;
            total_reg     <= total_next;
            skip_reg      <= skip_next;
            sample_reg    <= sample_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            out_data_reg  <= out_data_next;
        end
    end

    // The partial remainder always stays below the divisor while dividing.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < tpm_reg))
        else $error("divider remainder reached the divisor");

    // A new result only appears when the finishing step hands it over.
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result offered without a finished sample");

    // An accepted sample always keeps the block busy in the next cycle.
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after an input transfer");

    // The divider leaves its loop only when the step count is used up.
    a_div_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (count_reg != '0)) |=> (state_reg == ST_DIV))
        else $error("divider left before its last step");

endmodule

// ----- sim/tick_to_millisecond_timebase_tb.sv -----
// Self-checking testbench for the tick-to-millisecond timebase.
`timescale 1ns / 100ps

module tick_to_millisecond_timebase_tb;

    // Cycles without any transfer before the run is declared hung. The
    // longest legal quiet stretch is the receiver hold-off plus one division.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // Length of the long receiver hold-off, in clock cycles.
    localparam int unsigned HOLD_CYCLES    = 400;
    // Settling time after the last result, a little above the block latency.
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned RANDOM_ITEMS   = 150;

    localparam logic [tmt_pkg::TPM_WIDTH-1:0] TPM_MIN       = tmt_pkg::TPM_WIDTH'(1);
    localparam logic [tmt_pkg::TPM_WIDTH-1:0] TPM_MAX_RANGE =
        tmt_pkg::TPM_WIDTH'(85899345);
    localparam logic [tmt_pkg::TPM_WIDTH-1:0] TPM_ALL_ONES  = '1;
    localparam logic [tmt_pkg::TPM_WIDTH-1:0] TPM_ZERO      = '0;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS_READY,
        RX_RANDOM_STALL,
        RX_PERIODIC_STALL
    } rx_pattern_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tmt_pkg::TPM_WIDTH-1:0] cfg_wdata;

    tmt_sample_if sample_ch();
    tmt_total_if  total_ch();

    tick_to_millisecond_timebase uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch),
        .result    (total_ch)
    );

    // Shadow copy of the block state and its one register.
    logic [tmt_pkg::COUNT_WIDTH_DEFAULT-1:0] model_mark;
    logic [tmt_pkg::COUNT_WIDTH_DEFAULT-1:0] model_total;
    logic [tmt_pkg::TPM_WIDTH-1:0]           model_tpm;

    // Totals predicted for accepted samples, oldest first.
    logic [tmt_pkg::TOTAL_WIDTH-1:0] pending_totals[$];

    int unsigned  error_count   = 0;
    int unsigned  burst_left    = 0;
    bit           gaps_on       = 1'b1;
    // Each increment asks the receiver for one long hold-off.
    int unsigned  hold_requests = 0;
    rx_pattern_t  stall_mode    = RX_ALWAYS_READY;
    logic [tmt_pkg::SAMPLE_WIDTH-1:0] tick_now = '0;

    // Clock generation: 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Computes the new millisecond total for one sample and updates the shadow
    // state. An elapsed count that is an exact multiple of ticks_per_ms
    // leaves its last millisecond for a later sample, because the credit is
    // taken from elapsed - 1. A zero divisor credits nothing.
    function automatic logic [tmt_pkg::TOTAL_WIDTH-1:0] advance_timebase(
        input logic [tmt_pkg::SAMPLE_WIDTH-1:0] tick
    );
        logic [tmt_pkg::COUNT_WIDTH_DEFAULT-1:0] elapsed;
        logic [tmt_pkg::COUNT_WIDTH_DEFAULT-1:0] credit;
        logic [63:0]                             span;
        elapsed = tick - model_mark;
        if (elapsed != '0 && model_tpm != '0)
        begin
            credit      = (elapsed - 1) / {5'b0, model_tpm};
            span        = 64'(credit) * 64'(model_tpm);
            model_mark  = model_mark + span[tmt_pkg::COUNT_WIDTH_DEFAULT-1:0];
            model_total = model_total + credit;
        end
        return model_total;
    endfunction

    // Offers one sample and blocks until its transfer. The sender works in
    // bursts; at the end of a burst valid drops for a random gap. Valid is
    // left high after a transfer so back-to-back items never toggle it.
    task automatic send_sample(input logic [tmt_pkg::SAMPLE_WIDTH-1:0] tick);
        if (gaps_on && burst_left == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.tick_sample <= tick;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_totals.push_back(advance_timebase(tick));
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stops offering and waits until every predicted total has come back,
    // then lets the block settle so it is idle for a register write.
    task automatic wait_until_drained();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tpm(input logic [tmt_pkg::TPM_WIDTH-1:0] value);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_tpm  = value;
        @(posedge clk);
    endtask

    // Picks the next tick-counter sample. Most samples advance the counter
    // by amounts related to the divisor so that credits, exact multiples
    // and small remainders all occur; the rest jump, repeat or go backwards.
    function automatic logic [tmt_pkg::SAMPLE_WIDTH-1:0] next_tick();
        int unsigned pick;
        logic [63:0] unit;
        logic [63:0] step;
        unit = (model_tpm == '0) ? 64'd1000 : 64'(model_tpm);
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            step     = unit * $urandom_range(0, 4) + $urandom_range(0, 32'(unit - 1));
            tick_now = tick_now + step[tmt_pkg::SAMPLE_WIDTH-1:0];
        end
        else if (pick < 50)
        begin
            // Elapsed time exactly a whole number of milliseconds.
            step     = unit * $urandom_range(1, 3);
            tick_now = model_mark + step[tmt_pkg::SAMPLE_WIDTH-1:0];
        end
        else if (pick < 58)
            tick_now = tick_now;
        else if (pick < 66)
            tick_now = model_mark + tmt_pkg::SAMPLE_WIDTH'($urandom_range(0, 1));
        else if (pick < 74)
        begin
            step     = unit * $urandom_range(1, 6) + 1;
            tick_now = tick_now + step[tmt_pkg::SAMPLE_WIDTH-1:0];
        end
        else if (pick < 84)
            tick_now = $urandom;
        else if (pick < 92)
            tick_now = tick_now - $urandom_range(1, 32'(unit));
        else
            tick_now = tick_now + $urandom;
        return tick_now;
    endfunction

    // Default divisor after reset: a zero elapsed count, remainders just
    // below, at and above one millisecond, and an exact multiple.
    task automatic test_reset_defaults();
        send_sample(32'd0);
        send_sample(32'd9999);
        send_sample(32'd10000);
        send_sample(32'd10001);
        send_sample(32'd20000);
        send_sample(32'd20001);
    endtask

    // The counter wraps: a sample just below 2^32, then zero, then one just below the mark.
    task automatic test_counter_wrap();
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(model_mark - 1);
    endtask

    // Smallest divisor, the top of the range and the all-ones register.
    task automatic test_divisor_extremes();
        write_tpm(TPM_MIN);
        send_sample(model_mark);
        send_sample(model_mark + 1);
        send_sample(model_mark + 2);
        send_sample(32'hAAAA_AAAA);
        write_tpm(TPM_ALL_ONES);
        send_sample(model_mark + 32'hFFFF_FFFE);
        send_sample(32'h5555_5555);
        write_tpm(TPM_MAX_RANGE);
        send_sample(model_mark + 32'd50 * 32'(TPM_MAX_RANGE) + 1);
        send_sample(model_mark - 1);
    endtask

    // A zero divisor must leave the state alone and repeat the total.
    task automatic test_zero_divisor();
        write_tpm(TPM_ZERO);
        send_sample(32'h1234_5678);
        send_sample(model_mark);
        send_sample(32'hFFFF_FFFF);
        write_tpm(tmt_pkg::TPM_RESET);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering with no gaps, so the block fills and must stall its input.
    task automatic test_backpressure_fill();
        gaps_on      = 1'b0;
        stall_mode  <= RX_ALWAYS_READY;
        hold_requests++;
        tick_now     = model_mark;
        repeat (20)
            send_sample(next_tick());
        gaps_on = 1'b1;
    endtask

    // The sender pauses until everything is back, then resumes.
    task automatic test_drain_pause();
        wait_until_drained();
        repeat (5)
            send_sample(next_tick());
    endtask

    // Random phases, each with its own divisor, stall pattern and gap mode.
    task automatic test_random_timebase();
        logic [tmt_pkg::TPM_WIDTH-1:0] divisors[8];
        divisors[0] = TPM_MIN;
        divisors[1] = tmt_pkg::TPM_WIDTH'($urandom_range(2, 100));
        divisors[2] = tmt_pkg::TPM_RESET;
        divisors[3] = tmt_pkg::TPM_WIDTH'($urandom_range(1, 85899345));
        divisors[4] = TPM_MAX_RANGE;
        divisors[5] = tmt_pkg::TPM_WIDTH'($urandom_range(101, 50000));
        divisors[6] = TPM_ALL_ONES;
        divisors[7] = TPM_ZERO;
        for (int p = 0; p < 8; p++)
        begin
            write_tpm(divisors[p]);
            stall_mode <= rx_pattern_t'(p % 3);
            // Phase two runs with no sender idling at all.
            gaps_on     = (p != 2);
            tick_now    = (p == 4) ? 32'hFFF0_0000 : model_mark;
            for (int i = 0; i < RANDOM_ITEMS; i++)
                send_sample(next_tick());
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: checks each result transfer against the oldest prediction,
    // then chooses ready for the next cycle from the current stall pattern.
    // A new hold request starts a long hold-off counted here.
    initial
    begin : result_checker
        int unsigned hold_left;
        int unsigned holds_started;
        int unsigned rx_cycle;
        logic [tmt_pkg::TOTAL_WIDTH-1:0] want;
        hold_left      = 0;
        holds_started  = 0;
        rx_cycle       = 0;
        total_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rst_n && total_ch.valid && total_ch.ready)
            begin
                if (pending_totals.size() == 0)
                begin
                    $error("ms_total: unexpected result %0d with nothing expected",
                           total_ch.ms_total);
                    error_count++;
                end
                else
                begin
                    want = pending_totals.pop_front();
                    if (total_ch.ms_total !== want)
                    begin
                        $error("ms_total mismatch: expected %0d, actual %0d",
                               want, total_ch.ms_total);
                        error_count++;
                    end
                end
            end
            if (hold_requests != holds_started)
            begin
                hold_left     = HOLD_CYCLES;
                holds_started = hold_requests;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                total_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    RX_ALWAYS_READY:   total_ch.ready <= 1'b1;
                    RX_RANDOM_STALL:   total_ch.ready <= ($urandom_range(0, 9) < 7);
                    RX_PERIODIC_STALL: total_ch.ready <= ((rx_cycle % 11) >= 4);
                    default:           total_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (total_ch.valid && total_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Main sequence: reset once, run every test, drain and report.
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.tick_sample = '0;
        model_mark            = '0;
        model_total           = '0;
        model_tpm             = tmt_pkg::TPM_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        stall_mode <= RX_RANDOM_STALL;

        test_reset_defaults();
        test_counter_wrap();
        test_divisor_extremes();
        test_zero_divisor();
        test_backpressure_fill();
        test_drain_pause();
        test_random_timebase();

        // Everything is sent; wait for the last totals and let the block settle.
        wait_until_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
